/* sv/wrwa_pkg.sv */
package wrwa_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned KIB_W     = 32;
  localparam int unsigned RATE_W    = 40;
  localparam int unsigned CAP_W     = 10;
  localparam int unsigned TCNT_W    = 2;
  localparam int unsigned KIB_SHIFT = 10;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 40;

  localparam logic [CAP_W-1:0] CAP_RESET = 10'd1000;

  localparam int unsigned REG_CAPACITY = 0;
  localparam int unsigned REG_TCOUNT   = 1;
  localparam int unsigned REG_WIN_A    = 2;
  localparam int unsigned REG_RATE_A   = 3;
  localparam int unsigned REG_STRIDE   = 2;

  typedef struct packed {
    logic [TIME_W-1:0] elapsed;
    logic [KIB_W-1:0]  kib;
  } hist_t;

  typedef struct packed {
    logic done;
    logic hit;
  } mul_stat_t;

endpackage

/* sv/wrwa_if.sv */
interface wrwa_in_if;
  logic                          valid;
  logic                          ready;
  logic [wrwa_pkg::TIME_W-1:0]   now_seconds;
  logic [wrwa_pkg::KIB_W-1:0]    written_kib;

  modport source (output valid, now_seconds, written_kib, input ready);
  modport sink   (input valid, now_seconds, written_kib, output ready);
endinterface

interface wrwa_out_if;
  logic valid;
  logic ready;
  logic alarm;
  logic sample_kept;

  modport source (output valid, alarm, sample_kept, input ready);
  modport sink   (input valid, alarm, sample_kept, output ready);
endinterface

/* sv/wrwa_mul.sv */
module wrwa_mul #(
  parameter int unsigned SUM_W = 42
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic [wrwa_pkg::RATE_W-1:0]               rate_i,
  input  logic [SUM_W-1:0]                          dur_i,
  input  logic [SUM_W+wrwa_pkg::KIB_SHIFT-1:0]      lhs_i,
  output wrwa_pkg::mul_stat_t                       stat_o
);

  localparam int unsigned PW = wrwa_pkg::RATE_W + SUM_W;
  localparam int unsigned LW = SUM_W + wrwa_pkg::KIB_SHIFT;

  logic          busy_q;
  logic          done_q;
  logic          hit_q;
  logic [PW-1:0] mcand_q;
  logic [PW-1:0] acc_q;
  logic [SUM_W-1:0] mplier_q;
  logic [LW-1:0] lhs_q;

  // shift-add: one multiplier bit per cycle, stops once the remaining bits are zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
      mcand_q  <= '0;
      acc_q    <= '0;
      mplier_q <= '0;
      lhs_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        mcand_q  <= PW'(rate_i);
        mplier_q <= dur_i;
        acc_q    <= '0;
        lhs_q    <= lhs_i;
        busy_q   <= 1'b1;
      end else if (busy_q) begin
        if (mplier_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          hit_q  <= (acc_q <= PW'(lhs_q));
        end else begin
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.hit  = hit_q;

endmodule

/* sv/write_rate_window_alarm.sv */
// Write-rate window alarm. Each input beat is a poll (time in seconds, KiB written since the
// last poll); each poll yields exactly one output beat. A poll taken while the stored time is
// zero only records the time (sample_kept = 0). Other polls append (elapsed, KiB) to a history
// ring of HISTORY_DEPTH entries held in a single-port-read memory, then each enabled threshold
// walks the history newest to oldest at one entry per cycle and, unless skipped, compares
// KiB*1024 against rate*duration with a shift-add multiplier that retires one bit per cycle.
// The multiplier's duration operand is 32+log2(HISTORY_DEPTH) bits wide. How long a poll takes
// depends on the history walk through the memory read port and on the multiplier. Input is
// not ready while a poll is in progress. The history needs no clearing pass after reset.
module write_rate_window_alarm #(
  parameter int unsigned HISTORY_DEPTH   = 1024,
  parameter int unsigned THRESHOLD_SLOTS = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  wrwa_in_if.sink                            in_i,
  wrwa_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [wrwa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wrwa_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W = wrwa_pkg::TIME_W + AW;
  localparam int unsigned LW    = SUM_W + wrwa_pkg::KIB_SHIFT;
  localparam int unsigned TC_W  = $clog2(THRESHOLD_SLOTS + 1);
  localparam int unsigned TI_W  = (THRESHOLD_SLOTS > 1) ? $clog2(THRESHOLD_SLOTS) : 1;
  localparam int unsigned CMP_W = (FW > wrwa_pkg::CAP_W + 1) ? FW : wrwa_pkg::CAP_W + 1;
  localparam int unsigned TCNT_EXT = 8;
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_EVAL,
    ST_MUL,
    ST_NEXT,
    ST_DONE
  } state_e;

  // configuration
  logic [wrwa_pkg::CAP_W-1:0]  cap_q;
  logic [wrwa_pkg::TCNT_W-1:0] tcnt_q;
  logic [wrwa_pkg::TIME_W-1:0] win_q  [THRESHOLD_SLOTS];
  logic [wrwa_pkg::RATE_W-1:0] rate_q [THRESHOLD_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= wrwa_pkg::CAP_RESET;
      tcnt_q <= '0;
      for (int s = 0; s < THRESHOLD_SLOTS; s++) begin
        win_q[s]  <= '0;
        rate_q[s] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wrwa_pkg::CFG_IDX_W'(wrwa_pkg::REG_CAPACITY)) begin
        cap_q <= cfg_wdata_i[wrwa_pkg::CAP_W-1:0];
      end
      if (cfg_idx_i == wrwa_pkg::CFG_IDX_W'(wrwa_pkg::REG_TCOUNT)) begin
        tcnt_q <= cfg_wdata_i[wrwa_pkg::TCNT_W-1:0];
      end
      for (int s = 0; s < THRESHOLD_SLOTS; s++) begin
        if (cfg_idx_i == wrwa_pkg::CFG_IDX_W'(wrwa_pkg::REG_WIN_A + wrwa_pkg::REG_STRIDE * s)) begin
          win_q[s] <= cfg_wdata_i[wrwa_pkg::TIME_W-1:0];
        end
        if (cfg_idx_i == wrwa_pkg::CFG_IDX_W'(wrwa_pkg::REG_RATE_A + wrwa_pkg::REG_STRIDE * s)) begin
          rate_q[s] <= cfg_wdata_i[wrwa_pkg::RATE_W-1:0];
        end
      end
    end
  end

  // sequencer state
  state_e              state_q;
  logic [TC_W-1:0]     t_q;
  logic [AW-1:0]       ptr_q;
  logic [AW-1:0]       newest_q;
  logic [AW-1:0]       wr_q;
  logic [AW-1:0]       oldest_q;
  logic [FW-1:0]       fill_q;
  logic [wrwa_pkg::TIME_W-1:0] last_q;
  logic [SUM_W-1:0]    dur_q;
  logic [SUM_W-1:0]    kib_q;
  logic [FW-1:0]       polls_q;
  logic                rd_vld_q;
  logic                hit_q;
  logic                kept_q;
  logic                mul_start_q;
  logic                res_vld_q;
  logic                res_alarm_q;
  logic                res_kept_q;

  // history memory
  wrwa_pkg::hist_t     hist_mem [HISTORY_DEPTH];
  wrwa_pkg::hist_t     rd_data_q;
  wrwa_pkg::hist_t     wr_entry;
  logic                mem_we;
  logic                rd_en;

  logic                in_fire;
  logic [wrwa_pkg::TIME_W-1:0] elapsed;
  logic [TC_W-1:0]     n_thr;
  logic [TC_W-1:0]     t_inc;
  logic [SUM_W-1:0]    dur_new;
  logic [SUM_W-1:0]    kib_new;
  logic [FW-1:0]       polls_new;
  logic                walk_done;
  logic [wrwa_pkg::TIME_W-1:0] cur_win;
  logic [wrwa_pkg::RATE_W-1:0] cur_rate;
  logic [CMP_W-1:0]    fill_ext;
  logic [CMP_W-1:0]    cap_ext;
  logic                full;
  logic                skip;
  wrwa_pkg::mul_stat_t mul_stat;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    slot_inc = (p == LAST_SLOT) ? '0 : AW'(p + 1'b1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] p);
    slot_dec = (p == '0) ? LAST_SLOT : AW'(p - 1'b1);
  endfunction

  assign in_fire  = in_i.valid && in_i.ready;
  assign elapsed  = (in_i.now_seconds >= last_q) ? in_i.now_seconds - last_q : '0;
  assign n_thr    = (TCNT_EXT'(tcnt_q) > TCNT_EXT'(THRESHOLD_SLOTS)) ?
                    TC_W'(THRESHOLD_SLOTS) : TC_W'(tcnt_q);
  assign t_inc    = TC_W'(t_q + 1'b1);
  assign dur_new  = dur_q + SUM_W'(rd_data_q.elapsed);
  assign kib_new  = kib_q + SUM_W'(rd_data_q.kib);
  assign polls_new = FW'(polls_q + 1'b1);
  assign cur_win  = win_q[t_q[TI_W-1:0]];
  assign cur_rate = rate_q[t_q[TI_W-1:0]];
  assign walk_done = rd_vld_q && ((dur_new >= SUM_W'(cur_win)) || (polls_new == fill_q));
  assign rd_en    = (state_q == ST_WALK) && !walk_done;
  assign fill_ext = CMP_W'(fill_q);
  assign cap_ext  = CMP_W'(cap_q);
  assign full     = (fill_q == FW'(HISTORY_DEPTH));
  assign skip     = (polls_q == fill_q) && (fill_ext <= cap_ext) && (SUM_W'(cur_win) > dur_q);
  assign mem_we   = in_fire && (last_q != '0);
  assign wr_entry.elapsed = elapsed;
  assign wr_entry.kib     = in_i.written_kib;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wr_q] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[ptr_q];
    end
  end

  wrwa_mul #(
    .SUM_W (SUM_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .rate_i  (cur_rate),
    .dur_i   (dur_q),
    .lhs_i   (LW'(kib_q) << wrwa_pkg::KIB_SHIFT),
    .stat_o  (mul_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      ptr_q       <= '0;
      newest_q    <= '0;
      wr_q        <= '0;
      oldest_q    <= '0;
      fill_q      <= '0;
      last_q      <= '0;
      dur_q       <= '0;
      kib_q       <= '0;
      polls_q     <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      kept_q      <= 1'b0;
      mul_start_q <= 1'b0;
      res_vld_q   <= 1'b0;
      res_alarm_q <= 1'b0;
      res_kept_q  <= 1'b0;
    end else begin
      mul_start_q <= 1'b0;
      if (res_vld_q && out_o.ready) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            last_q  <= in_i.now_seconds;
            hit_q   <= 1'b0;
            t_q     <= '0;
            dur_q   <= '0;
            kib_q   <= '0;
            polls_q <= '0;
            rd_vld_q <= 1'b0;
            if (last_q == '0) begin
              kept_q  <= 1'b0;
              state_q <= ST_DONE;
            end else begin
              kept_q   <= 1'b1;
              wr_q     <= slot_inc(wr_q);
              newest_q <= wr_q;
              ptr_q    <= wr_q;
              if (full) begin
                oldest_q <= slot_inc(oldest_q);
              end else begin
                fill_q <= FW'(fill_q + 1'b1);
              end
              state_q <= (n_thr == '0) ? ST_DONE : ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (rd_vld_q) begin
            dur_q   <= dur_new;
            kib_q   <= kib_new;
            polls_q <= polls_new;
          end
          if (walk_done) begin
            rd_vld_q <= 1'b0;
            state_q  <= ST_EVAL;
          end else begin
            rd_vld_q <= 1'b1;
            ptr_q    <= slot_dec(ptr_q);
          end
        end
        ST_EVAL: begin
          if (skip) begin
            state_q <= ST_NEXT;
          end else if (dur_q == '0) begin
            if (kib_q != '0) begin
              hit_q   <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_NEXT;
            end
          end else begin
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            if (mul_stat.hit) begin
              hit_q   <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_NEXT;
            end
          end
        end
        ST_NEXT: begin
          if (t_inc == n_thr) begin
            state_q <= ST_DONE;
          end else begin
            t_q      <= t_inc;
            ptr_q    <= newest_q;
            dur_q    <= '0;
            kib_q    <= '0;
            polls_q  <= '0;
            rd_vld_q <= 1'b0;
            state_q  <= ST_WALK;
          end
        end
        ST_DONE: begin
          if (!res_vld_q || out_o.ready) begin
            res_vld_q   <= 1'b1;
            res_alarm_q <= hit_q;
            res_kept_q  <= kept_q;
            if (kept_q && (fill_ext > cap_ext)) begin
              oldest_q <= slot_inc(oldest_q);
              fill_q   <= FW'(fill_q - 1'b1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = res_vld_q;
  assign out_o.alarm       = res_alarm_q;
  assign out_o.sample_kept = res_kept_q;

endmodule
